// ===== rtl/core/vhb_pkg.sv =====
`default_nettype none

package vhb_pkg;

   // Default sizes handed to the top level.
   localparam int NUM_BINS_DEF    = 1024;
   localparam int SAMPLE_BITS_DEF = 32;

   // Field widths fixed by the interface.
   localparam int OPCODE_W  = 2;
   localparam int STATUS_W  = 2;
   localparam int INDEX_W   = 10;
   localparam int COUNT_W   = 32;
   localparam int SUM_W     = 64;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_W     = 32;
   localparam int USED_W    = 11;

   // Wide enough to hold any bin number up to the largest store, plus one.
   localparam int BIN_EXT_W = 17;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_ADD_SAMPLE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ_BIN   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ_BELOW = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_ABOVE = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_BINNED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BELOW   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABOVE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_READOUT = 2'd3;

   // Register indexes on the control port.
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_LOW   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_HIGH  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIN_SCALE   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BINS_IN_USE = 8'd3;

   // Register reset values.
   localparam logic [31:0]       RANGE_LOW_RST   = 32'd0;
   localparam logic [31:0]       RANGE_HIGH_RST  = 32'd1023;
   localparam logic [31:0]       BIN_SCALE_RST   = 32'd65536;
   localparam logic [USED_W-1:0] BINS_IN_USE_RST = 11'd1024;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic diff;
      logic prod;
      logic bin;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/vhb_ctrl.sv =====
`default_nettype none

module vhb_ctrl #(
   parameter int NUM_BINS = vhb_pkg::NUM_BINS_DEF,
   parameter int BIN_W    = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire vhb_pkg::stat_type    stat,
   output vhb_pkg::cmd_type          cmd,
   output logic [BIN_W-1:0]          clr_addr
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_DIFF  = 7'b0000100,
      S_PROD  = 7'b0001000,
      S_BIN   = 7'b0010000,
      S_READ  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   localparam logic [BIN_W-1:0] LAST_ADDR = BIN_W'(NUM_BINS - 1);

   state_type        state_ff, state_in;
   logic [BIN_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             accept;
   logic             clr_last;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign clr_last  = (clr_cnt_ff == LAST_ADDR);
   assign clr_addr  = clr_cnt_ff;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      cmd        = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear  = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_BIN;
         end
         S_BIN: begin
            cmd.bin  = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // State registers; reset restarts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // An accepted item always moves straight into the difference step.
   a_accept_to_diff: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DIFF)
      else $error("accepted item did not start processing");

   // The clearing pass ends after the last entry.
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) && clr_last |=> state_ff == S_IDLE)
      else $error("clearing pass did not end at the last entry");

   // A finished item returns the controller to idle.
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && stat.out_free |=> state_ff == S_IDLE)
      else $error("controller did not return to idle after finishing");

endmodule

`default_nettype wire

// ===== rtl/core/vhb_datapath.sv =====
`default_nettype none

module vhb_datapath #(
   parameter int NUM_BINS    = vhb_pkg::NUM_BINS_DEF,
   parameter int SAMPLE_BITS = vhb_pkg::SAMPLE_BITS_DEF,
   parameter int BIN_W       = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire vhb_pkg::cmd_type                     cmd,
   output vhb_pkg::stat_type                         stat,
   input  wire logic [BIN_W-1:0]                     clr_addr,
   input  wire logic [vhb_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic [SAMPLE_BITS-1:0]               req_sample,
   input  wire logic [vhb_pkg::INDEX_W-1:0]          req_bin_index,
   input  wire logic                                 csr_valid,
   input  wire logic [vhb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [vhb_pkg::CSR_W-1:0]            csr_wdata,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [vhb_pkg::STATUS_W-1:0]              rsp_status,
   output logic [vhb_pkg::INDEX_W-1:0]               rsp_bin_out,
   output logic [vhb_pkg::COUNT_W-1:0]               rsp_count,
   output logic [vhb_pkg::SUM_W-1:0]                 rsp_sum
);

   localparam int CW   = ((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32) + 1;
   localparam int EW   = vhb_pkg::BIN_EXT_W;
   localparam int CNTW = vhb_pkg::COUNT_W;
   localparam int SUMW = vhb_pkg::SUM_W;
   localparam logic [EW-1:0] NB_EXT = EW'(NUM_BINS);

   // Configuration registers.
   logic [31:0]                  range_low_ff, range_high_ff, bin_scale_ff;
   logic [vhb_pkg::USED_W-1:0]   bins_used_ff;

   // Item registers.
   logic [vhb_pkg::OPCODE_W-1:0] op_ff;
   logic [SAMPLE_BITS-1:0]       smp_ff;
   logic [vhb_pkg::INDEX_W-1:0]  idx_ff;

   // Pipeline registers.
   logic [CW-1:0]                diff_ff;
   logic                         below_hit_ff, above_hit_ff;
   logic [63:0]                  prod_ff;
   logic                         diff_hi_ff;
   logic [BIN_W-1:0]             bin_ff;
   logic                         miss_ff;
   logic [CNTW-1:0]              rd_cnt_ff;
   logic [SUMW-1:0]              rd_sum_ff;

   // Out-of-range counters.
   logic [CNTW-1:0]              below_ff, below_in, above_ff, above_in;

   // Bin store.
   logic [CNTW-1:0]              cnt_mem [NUM_BINS];
   logic [SUMW-1:0]              sum_mem [NUM_BINS];

   // Result register.
   logic                         rsp_valid_ff;
   logic [vhb_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [vhb_pkg::INDEX_W-1:0]  bin_out_ff, bin_out_in;
   logic [CNTW-1:0]              count_ff, count_in;
   logic [SUMW-1:0]              sum_ff, sum_in;

   // Combinational helpers.
   logic [CW-1:0]                s_ext, lo_ext, hi_ext;
   logic [EW-1:0]                used_c, last_ext, idx_ext, bin_ext;
   logic [47:0]                  quot;
   logic [BIN_W-1:0]             bin_calc;
   logic [SUMW-1:0]              smp_sum;
   logic                         wr_en;
   logic [BIN_W-1:0]             wr_addr;
   logic [CNTW-1:0]              wr_cnt;
   logic [SUMW-1:0]              wr_sum;

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= vhb_pkg::RANGE_LOW_RST;
         range_high_ff <= vhb_pkg::RANGE_HIGH_RST;
         bin_scale_ff  <= vhb_pkg::BIN_SCALE_RST;
         bins_used_ff  <= vhb_pkg::BINS_IN_USE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            vhb_pkg::REG_RANGE_LOW:   range_low_ff  <= csr_wdata;
            vhb_pkg::REG_RANGE_HIGH:  range_high_ff <= csr_wdata;
            vhb_pkg::REG_BIN_SCALE:   bin_scale_ff  <= csr_wdata;
            vhb_pkg::REG_BINS_IN_USE: bins_used_ff  <= csr_wdata[vhb_pkg::USED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sign-extended operands for the range test.
   assign s_ext  = {{(CW-SAMPLE_BITS){smp_ff[SAMPLE_BITS-1]}}, smp_ff};
   assign lo_ext = {{(CW-32){range_low_ff[31]}}, range_low_ff};
   assign hi_ext = {{(CW-32){range_high_ff[31]}}, range_high_ff};

   // Bin number from the scaled product, clamped to the last bin in use.
   always_comb begin
      if (bins_used_ff == '0) begin
         used_c = EW'(1);
      end else if (EW'(bins_used_ff) > NB_EXT) begin
         used_c = NB_EXT;
      end else begin
         used_c = EW'(bins_used_ff);
      end
      last_ext = used_c - 1'b1;
      quot     = prod_ff[63:16];
      if (diff_hi_ff || (quot > 48'(last_ext))) begin
         bin_calc = last_ext[BIN_W-1:0];
      end else begin
         bin_calc = quot[BIN_W-1:0];
      end
      idx_ext = EW'(idx_ff);
   end

   // Item capture and the arithmetic steps.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         smp_ff <= req_sample;
         idx_ff <= req_bin_index;
      end
      if (cmd.diff) begin
         diff_ff      <= s_ext - lo_ext;
         below_hit_ff <= $signed(s_ext) < $signed(lo_ext);
         above_hit_ff <= $signed(s_ext) > $signed(hi_ext);
      end
      if (cmd.prod) begin
         prod_ff    <= 64'(diff_ff[31:0]) * 64'(bin_scale_ff);
         diff_hi_ff <= (|diff_ff[CW-1:32]) && (bin_scale_ff != '0);
      end
      if (cmd.bin) begin
         if (op_ff == vhb_pkg::OP_ADD_SAMPLE) begin
            bin_ff <= bin_calc;
         end else begin
            bin_ff <= idx_ext[BIN_W-1:0];
         end
         miss_ff <= (idx_ext >= NB_EXT);
      end
   end

   // Result, counter update and store write for the finishing item.
   always_comb begin
      smp_sum    = {{(SUMW-SAMPLE_BITS){smp_ff[SAMPLE_BITS-1]}}, smp_ff};
      bin_ext    = EW'(bin_ff);
      below_in   = below_ff;
      above_in   = above_ff;
      status_in  = vhb_pkg::ST_READOUT;
      bin_out_in = '0;
      count_in   = '0;
      sum_in     = '0;
      wr_en      = 1'b0;
      wr_addr    = bin_ff;
      wr_cnt     = rd_cnt_ff + 1'b1;
      wr_sum     = rd_sum_ff + smp_sum;
      case (op_ff)
         vhb_pkg::OP_ADD_SAMPLE: begin
            if (below_hit_ff) begin
               if (below_ff != vhb_pkg::COUNT_MAX) begin
                  below_in = below_ff + 1'b1;
               end
               status_in = vhb_pkg::ST_BELOW;
               count_in  = below_in;
            end else if (above_hit_ff) begin
               if (above_ff != vhb_pkg::COUNT_MAX) begin
                  above_in = above_ff + 1'b1;
               end
               status_in = vhb_pkg::ST_ABOVE;
               count_in  = above_in;
            end else begin
               status_in  = vhb_pkg::ST_BINNED;
               bin_out_in = bin_ext[vhb_pkg::INDEX_W-1:0];
               if (rd_cnt_ff != vhb_pkg::COUNT_MAX) begin
                  wr_en    = cmd.finish;
                  count_in = wr_cnt;
                  sum_in   = wr_sum;
               end else begin
                  count_in = rd_cnt_ff;
                  sum_in   = rd_sum_ff;
               end
            end
         end
         vhb_pkg::OP_READ_BIN: begin
            bin_out_in = idx_ff;
            if (!miss_ff) begin
               count_in = rd_cnt_ff;
               sum_in   = rd_sum_ff;
            end
         end
         vhb_pkg::OP_READ_BELOW: begin
            count_in = below_ff;
         end
         vhb_pkg::OP_READ_ABOVE: begin
            count_in = above_ff;
         end
         default: begin
         end
      endcase
      // The clearing pass owns the write port after reset.
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr;
         wr_cnt  = '0;
         wr_sum  = '0;
      end
   end

   // Bin store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_addr] <= wr_cnt;
         sum_mem[wr_addr] <= wr_sum;
      end
      rd_cnt_ff <= cnt_mem[bin_ff];
      rd_sum_ff <= sum_mem[bin_ff];
   end

   // Out-of-range counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         below_ff <= '0;
         above_ff <= '0;
      end else if (cmd.finish) begin
         below_ff <= below_in;
         above_ff <= above_in;
      end
   end

   // Result register, freed when the item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         status_ff  <= status_in;
         bin_out_ff <= bin_out_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_bin_out = bin_out_ff;
   assign rsp_count   = count_ff;
   assign rsp_sum     = sum_ff;

   // A finished item always shows up on the result channel.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item was not presented");

   // Out-of-range counters only ever grow.
   a_below_grows: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (below_ff >= $past(below_ff)) && (above_ff >= $past(above_ff)))
      else $error("out-of-range counter went down");

   // A waiting result keeps its payload until it is taken.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(status_ff) &&
         $stable(bin_out_ff) && $stable(count_ff) && $stable(sum_ff))
      else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

// ===== rtl/core/value_histogram_binner_unit.sv =====
// A result is valid once its item has passed the difference, multiply, bin select,
// store read and update steps, and one item is in flight at a time.
// A new item is accepted only after the last one has finished; the controller holds one
// item through all five steps, with the 32x32 multiply registered in a step of its own.
// Reset (synchronous, active high) restores the registers and then runs a clearing
// pass over every entry of the bin store, during which no item is accepted.
`default_nettype none

module value_histogram_binner_unit #(
   parameter int NUM_BINS    = vhb_pkg::NUM_BINS_DEF,
   parameter int SAMPLE_BITS = vhb_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [vhb_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic [SAMPLE_BITS-1:0]               req_sample,
   input  wire logic [vhb_pkg::INDEX_W-1:0]          req_bin_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [vhb_pkg::STATUS_W-1:0]              rsp_status,
   output logic [vhb_pkg::INDEX_W-1:0]               rsp_bin_out,
   output logic [vhb_pkg::COUNT_W-1:0]               rsp_count,
   output logic [vhb_pkg::SUM_W-1:0]                 rsp_sum,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [vhb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [vhb_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

   vhb_pkg::cmd_type  cmd;
   vhb_pkg::stat_type stat;
   logic [BIN_W-1:0]  clr_addr;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   vhb_ctrl #(
      .NUM_BINS (NUM_BINS),
      .BIN_W    (BIN_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd),
      .clr_addr  (clr_addr)
   );

   vhb_datapath #(
      .NUM_BINS    (NUM_BINS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .BIN_W       (BIN_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .clr_addr      (clr_addr),
      .req_opcode    (req_opcode),
      .req_sample    (req_sample),
      .req_bin_index (req_bin_index),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_bin_out   (rsp_bin_out),
      .rsp_count     (rsp_count),
      .rsp_sum       (rsp_sum)
   );

endmodule

`default_nettype wire
